[src/sfid_pkg.sv]
`timescale 1ns / 1ps

package sfid_pkg;

    // Width of one map word and of the bit position inside it.
    localparam int WORD_BITS = 32;
    localparam int POS_BITS  = 5;

    // Width of an identifier field on the ports.
    localparam int ID_BITS = 17;

    // Request operation codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_WAS_FREE = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [ID_BITS-1:0] release_id;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0] granted_id;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_L2,
        ST_ALLOC_L1,
        ST_ALLOC_L0,
        ST_REL_UPD,
        ST_RESP
    } state_t;

    // Position of the lowest clear bit of a word; zero when the word is all ones.
    function automatic logic [POS_BITS-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [POS_BITS-1:0] pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!w[b])
            begin
                pos = POS_BITS'(b);
            end
        end
        return pos;
    endfunction

endpackage

[src/sfid_word_mem.sv]
`timescale 1ns / 1ps

module sfid_word_mem
    import sfid_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/smallest_free_id_allocator_core.sv]
`timescale 1ns / 1ps
// Allocate: the result is registered after one read each of the level-2, level-1 and leaf
// memories in turn; release and refused requests go straight to their finishing state. One
// request is in flight at a time; the next is accepted the cycle after the result is loaded
// into the output register.
// After reset a clearing pass zeroes the memories one word at a time, during which no request
// is accepted.
module smallest_free_id_allocator_core
    import sfid_pkg::*;
#(
    parameter int NUM_IDS = 65536
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Word counts of the leaf map and of the two summary levels.
    localparam int W0  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int W1  = (W0 + WORD_BITS - 1) / WORD_BITS;
    localparam int W2  = (W1 + WORD_BITS - 1) / WORD_BITS;
    localparam int A0W = (W0 > 1) ? $clog2(W0) : 1;
    localparam int A1W = (W1 > 1) ? $clog2(W1) : 1;
    localparam int A2W = (W2 > 1) ? $clog2(W2) : 1;

    // Bits of each last word that stand for nothing; they read as used.
    localparam int V0 = NUM_IDS - WORD_BITS * (W0 - 1);
    localparam int V1 = W0 - WORD_BITS * (W1 - 1);
    localparam int V2 = W1 - WORD_BITS * (W2 - 1);
    localparam logic [63:0] FILL0 = (64'd1 << V0) - 64'd1;
    localparam logic [63:0] FILL1 = (64'd1 << V1) - 64'd1;
    localparam logic [63:0] FILL2 = (64'd1 << V2) - 64'd1;
    localparam logic [63:0] FILLT = (64'd1 << W2) - 64'd1;
    localparam logic [WORD_BITS-1:0] PAD0 = ~FILL0[WORD_BITS-1:0];
    localparam logic [WORD_BITS-1:0] PAD1 = ~FILL1[WORD_BITS-1:0];
    localparam logic [WORD_BITS-1:0] PAD2 = ~FILL2[WORD_BITS-1:0];
    localparam logic [WORD_BITS-1:0] PADT = ~FILLT[WORD_BITS-1:0];

    state_t state_reg, state_next;

    logic [A0W-1:0]       i0_reg, i0_next;
    logic [A1W-1:0]       i1_reg, i1_next;
    logic [A2W-1:0]       i2_reg, i2_next;
    logic [POS_BITS-1:0]  p0_reg, p0_next;
    logic [POS_BITS-1:0]  p1_reg, p1_next;
    logic [POS_BITS-1:0]  p2_reg, p2_next;
    logic [WORD_BITS-1:0] top_reg, top_next;
    logic [A0W-1:0]       clr_cnt_reg, clr_cnt_next;
    rsp_t                 res_reg, res_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic accept;
    logic out_free;
    logic load;
    rsp_t load_data;

    // Memory ports.
    logic                 we0, we1, we2;
    logic                 re0, re1, re2;
    logic [A0W-1:0]       waddr0, raddr0;
    logic [A1W-1:0]       waddr1, raddr1;
    logic [A2W-1:0]       waddr2, raddr2;
    logic [WORD_BITS-1:0] wdata0, wdata1, wdata2;
    logic [WORD_BITS-1:0] rd0, rd1, rd2;

    // Datapath values.
    logic [31:0]          rel_k;
    logic                 rel_ok;
    logic [A0W-1:0]       rel_a0;
    logic [A1W-1:0]       rel_a1;
    logic [A2W-1:0]       rel_a2;
    logic [WORD_BITS-1:0] top_masked;
    logic [POS_BITS-1:0]  top_pos;
    logic [WORD_BITS-1:0] pad0_sel, pad1_sel, pad2_sel;
    logic [WORD_BITS-1:0] rd0_m, rd1_m, rd2_m;
    logic [POS_BITS-1:0]  p0_pos, p1_pos, p2_pos;
    logic [A2W+POS_BITS-1:0] l1_cat;
    logic [A1W+POS_BITS-1:0] l0_cat;
    logic [A0W+POS_BITS-1:0] id_cat;
    logic [A1W-1:0]       l1_idx;
    logic [A0W-1:0]       l0_idx;
    logic [31:0]          gid32;
    logic [WORD_BITS-1:0] aw0, aw1, aw2;
    logic                 full0, full1, full2;
    logic [POS_BITS-1:0]  top_bit;

    sfid_word_mem #(.DEPTH(W0), .AW(A0W)) u_leaf_mem (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .re    (re0),
        .raddr (raddr0),
        .rdata (rd0)
    );

    sfid_word_mem #(.DEPTH(W1), .AW(A1W)) u_l1_mem (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (re1),
        .raddr (raddr1),
        .rdata (rd1)
    );

    sfid_word_mem #(.DEPTH(W2), .AW(A2W)) u_l2_mem (
        .clk   (clk),
        .we    (we2),
        .waddr (waddr2),
        .wdata (wdata2),
        .re    (re2),
        .raddr (raddr2),
        .rdata (rd2)
    );

    // Release request decode: word addresses and bit positions at every level.
    assign rel_k  = 32'(req.release_id) - 32'd1;
    assign rel_ok = (req.release_id != '0) && (32'(req.release_id) <= 32'(NUM_IDS));
    assign rel_a0 = rel_k[A0W+POS_BITS-1:POS_BITS];
    assign rel_a1 = rel_k[A1W+2*POS_BITS-1:2*POS_BITS];
    assign rel_a2 = rel_k[A2W+3*POS_BITS-1:3*POS_BITS];

    // Search of the top summary register.
    assign top_masked = top_reg | PADT;
    assign top_pos    = lowest_zero(top_masked);

    // Padding of the word being looked at, per level.
    assign pad0_sel = (i0_reg == A0W'(W0 - 1)) ? PAD0 : '0;
    assign pad1_sel = (i1_reg == A1W'(W1 - 1)) ? PAD1 : '0;
    assign pad2_sel = (i2_reg == A2W'(W2 - 1)) ? PAD2 : '0;
    assign rd0_m    = rd0 | pad0_sel;
    assign rd1_m    = rd1 | pad1_sel;
    assign rd2_m    = rd2 | pad2_sel;
    assign p0_pos   = lowest_zero(rd0_m);
    assign p1_pos   = lowest_zero(rd1_m);
    assign p2_pos   = lowest_zero(rd2_m);

    // Next word index down the descent, and the granted identifier.
    assign l1_cat = {i2_reg, p2_pos};
    assign l1_idx = l1_cat[A1W-1:0];
    assign l0_cat = {i1_reg, p1_pos};
    assign l0_idx = l0_cat[A0W-1:0];
    assign id_cat = {i0_reg, p0_pos};
    assign gid32  = 32'(id_cat) + 32'd1;

    // Allocate write-back: set the leaf bit and carry "full" up the levels.
    assign aw0   = rd0 | (WORD_BITS'(1) << p0_pos);
    assign full0 = &(aw0 | pad0_sel);
    assign aw1   = rd1 | (WORD_BITS'(full0) << p1_reg);
    assign full1 = &(aw1 | pad1_sel);
    assign aw2   = rd2 | (WORD_BITS'(full1) << p2_reg);
    assign full2 = &(aw2 | pad2_sel);
    assign top_bit = POS_BITS'(i2_reg);

    // Handshake status.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == A0W'(W0 - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        state_next = (&top_masked) ? ST_RESP : ST_ALLOC_L2;
                    end
                    else
                    begin
                        state_next = rel_ok ? ST_REL_UPD : ST_RESP;
                    end
                end
            end
            ST_ALLOC_L2:
            begin
                state_next = ST_ALLOC_L1;
            end
            ST_ALLOC_L1:
            begin
                state_next = ST_ALLOC_L0;
            end
            ST_ALLOC_L0, ST_REL_UPD, ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory control, descent registers and result hand-off.
    always_comb
    begin
        re0 = 1'b0;
        re1 = 1'b0;
        re2 = 1'b0;
        we0 = 1'b0;
        we1 = 1'b0;
        we2 = 1'b0;
        raddr0 = rel_a0;
        raddr1 = rel_a1;
        raddr2 = rel_a2;
        waddr0 = i0_reg;
        waddr1 = i1_reg;
        waddr2 = i2_reg;
        wdata0 = '0;
        wdata1 = '0;
        wdata2 = '0;
        i0_next = i0_reg;
        i1_next = i1_reg;
        i2_next = i2_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        top_next = top_reg;
        clr_cnt_next = clr_cnt_reg;
        res_next = res_reg;
        load = 1'b0;
        load_data = res_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one word per cycle of the leaf memory and, while their words last, of the summary memories.
                we0 = 1'b1;
                waddr0 = clr_cnt_reg;
                we1 = (clr_cnt_reg < A0W'(W1));
                waddr1 = clr_cnt_reg[A1W-1:0];
                we2 = (clr_cnt_reg < A0W'(W2));
                waddr2 = clr_cnt_reg[A2W-1:0];
                clr_cnt_next = clr_cnt_reg + A0W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        if (&top_masked)
                        begin
                            res_next.granted_id = '0;
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            re2 = 1'b1;
                            raddr2 = top_pos[A2W-1:0];
                            i2_next = top_pos[A2W-1:0];
                        end
                    end
                    else
                    begin
                        if (rel_ok)
                        begin
                            re0 = 1'b1;
                            re1 = 1'b1;
                            re2 = 1'b1;
                            i0_next = rel_a0;
                            i1_next = rel_a1;
                            i2_next = rel_a2;
                            p0_next = rel_k[POS_BITS-1:0];
                            p1_next = rel_k[2*POS_BITS-1:POS_BITS];
                            p2_next = rel_k[3*POS_BITS-1:2*POS_BITS];
                        end
                        else
                        begin
                            res_next.granted_id = '0;
                            res_next.status = STATUS_WAS_FREE;
                        end
                    end
                end
            end
            ST_ALLOC_L2:
            begin
                re1 = 1'b1;
                raddr1 = l1_idx;
                p2_next = p2_pos;
                i1_next = l1_idx;
            end
            ST_ALLOC_L1:
            begin
                re0 = 1'b1;
                raddr0 = l0_idx;
                p1_next = p1_pos;
                i0_next = l0_idx;
            end
            ST_ALLOC_L0:
            begin
                if (out_free)
                begin
                    we0 = 1'b1;
                    we1 = 1'b1;
                    we2 = 1'b1;
                    wdata0 = aw0;
                    wdata1 = aw1;
                    wdata2 = aw2;
                    top_next[top_bit] = full2;
                    load = 1'b1;
                    load_data.granted_id = gid32[ID_BITS-1:0];
                    load_data.status = STATUS_OK;
                end
            end
            ST_REL_UPD:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    load_data.granted_id = '0;
                    if (rd0[p0_reg])
                    begin
                        // A freed leaf bit means no level above is full any more.
                        we0 = 1'b1;
                        we1 = 1'b1;
                        we2 = 1'b1;
                        wdata0 = rd0 & ~(WORD_BITS'(1) << p0_reg);
                        wdata1 = rd1 & ~(WORD_BITS'(1) << p1_reg);
                        wdata2 = rd2 & ~(WORD_BITS'(1) << p2_reg);
                        top_next[top_bit] = 1'b0;
                        load_data.status = STATUS_OK;
                    end
                    else
                    begin
                        load_data.status = STATUS_WAS_FREE;
                    end
                end
            end
            ST_RESP:
            begin
                load = out_free;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_next = load_data;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            top_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            top_reg <= top_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and descent registers.
    always_ff @(posedge clk)
    begin
        i0_reg <= i0_next;
        i1_reg <= i1_next;
        i2_reg <= i2_next;
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

`ifndef NO_ASSERTIONS
    // The summaries must lead the descent only into words that still have a free bit.
    a_l2_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ALLOC_L2 |-> !(&rd2_m))
        else $error("level-2 word chosen by the top summary is full");

    a_l1_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ALLOC_L1 |-> !(&rd1_m))
        else $error("level-1 word chosen by the level-2 summary is full");

    a_l0_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ALLOC_L0 |-> !(&rd0_m))
        else $error("leaf word chosen by the level-1 summary is full");

    // A new result appears only out of one of the finishing states.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_ALLOC_L0
            || $past(state_reg) == ST_REL_UPD || $past(state_reg) == ST_RESP))
        else $error("result loaded outside a finishing state");
`endif

endmodule
